@@ rtl/core/gbe_pkg.sv @@
// Shared types, constants and helpers for the glyph bitmap expander.
// No dependencies; imported by gbe_emitter, gbe_checker and glyph_bitmap_expander_top.
package gbe_pkg;

    localparam int unsigned BYTE_BITS = 8;
    localparam int unsigned IDX_W     = 3;
    localparam int unsigned ORIGIN_W  = 15;
    localparam int unsigned COORD_W   = 16;
    localparam int unsigned DIM_W     = 8;
    localparam int unsigned COL_W     = 5;
    localparam int unsigned RBYTES_W  = 6;

    localparam logic [BYTE_BITS-1:0] BIT_MSB = 8'h80;

    // One expanded bitmap byte: which columns to write and where they land.
    typedef struct packed {
        logic [BYTE_BITS-1:0]      mask;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [DIM_W-1:0]          value;
    } byte_job_t;

    // Column (0 = bit 7) of the leftmost set bit of a byte mask.
    function automatic logic [IDX_W-1:0] first_pixel(input logic [BYTE_BITS-1:0] mask);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int b = BYTE_BITS - 1; b >= 0; b--)
        begin
            if (mask[BYTE_BITS-1-b])
            begin
                idx = IDX_W'(b);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/core/glyph_bitmap_expander_top.sv @@
// Glyph bitmap expander: turns 1-bit-per-pixel glyph bytes into pixel writes.
// Depends on gbe_pkg and gbe_emitter.
//
// Input channel (in_valid/in_ready) carries one bitmap byte per transfer, rows
// padded to whole bytes, leftmost pixel in bit 7. A byte with start_glyph set
// latches origin, width, height and draw value and restarts the row and byte
// counters. Output channel (out_valid/out_ready) carries one pixel write per
// transfer, in order of rising column; last_of_byte marks the final write
// caused by a byte. Bytes that cause no write (padding only, after the last
// row, zero width or height) are taken and produce no output transfer.
//
// Each accepted byte is held in the emitter's pending mask and payload
// registers, and each write in its result register. A byte with n set
// in-glyph bits (up to 8) makes n writes, one output transfer per cycle while
// the receiver takes them; the next byte is taken in the same cycle as the
// final write of the current one leaves; a byte with no writes leaves it idle.
// Reset clears geometry and counters to zero and empties both registers.
// When the receiver stalls, the result register holds its write and the
// pending byte waits; in_ready drops until that byte is drained.
module glyph_bitmap_expander_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [gbe_pkg::BYTE_BITS-1:0]      bitmap_byte,
    input  logic                               start_glyph,
    input  logic signed [gbe_pkg::ORIGIN_W-1:0] origin_x,
    input  logic signed [gbe_pkg::ORIGIN_W-1:0] origin_y,
    input  logic [gbe_pkg::DIM_W-1:0]          glyph_width,
    input  logic [gbe_pkg::DIM_W-1:0]          glyph_height,
    input  logic [gbe_pkg::DIM_W-1:0]          draw_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [gbe_pkg::COORD_W-1:0] pixel_x,
    output logic signed [gbe_pkg::COORD_W-1:0] pixel_y,
    output logic [gbe_pkg::DIM_W-1:0]          write_value,
    output logic                               last_of_byte
);
    import gbe_pkg::*;

    logic [ORIGIN_W-1:0] base_x_reg,  base_x_next;
    logic [ORIGIN_W-1:0] base_y_reg,  base_y_next;
    logic [DIM_W-1:0]    width_reg,   width_next;
    logic [DIM_W-1:0]    height_reg,  height_next;
    logic [DIM_W-1:0]    value_reg,   value_next;
    logic [COL_W-1:0]    byte_col_reg, byte_col_next;
    logic [DIM_W-1:0]    row_reg,     row_next;

    logic [RBYTES_W-1:0] bytes_per_row;
    logic [RBYTES_W-1:0] col_plus;
    logic                active;
    logic [DIM_W-1:0]    col;
    byte_job_t           job;
    logic                accept;

    assign accept = in_valid && in_ready;

    // Effective geometry for this byte: fresh from the ports on a glyph start.
    always_comb
    begin
        if (start_glyph)
        begin
            base_x_next   = origin_x;
            base_y_next   = origin_y;
            width_next    = glyph_width;
            height_next   = glyph_height;
            value_next    = draw_value;
            byte_col_next = '0;
            row_next      = '0;
        end
        else
        begin
            base_x_next   = base_x_reg;
            base_y_next   = base_y_reg;
            width_next    = width_reg;
            height_next   = height_reg;
            value_next    = value_reg;
            byte_col_next = byte_col_reg;
            row_next      = row_reg;
        end

        bytes_per_row = RBYTES_W'(({1'b0, width_next} + 9'(BYTE_BITS - 1)) >> IDX_W);
        active        = (bytes_per_row != '0) && (row_next < height_next);
        col_plus      = {1'b0, byte_col_next} + 6'd1;

        // Column mask: set bits inside the glyph width.
        job.mask = '0;
        for (int b = 0; b < BYTE_BITS; b++)
        begin
            col = {byte_col_next, IDX_W'(b)};
            job.mask[BYTE_BITS-1-b] = active && bitmap_byte[BYTE_BITS-1-b]
                                      && (col < width_next);
        end
        job.x     = $signed({base_x_next[ORIGIN_W-1], base_x_next})
                    + $signed({{(COORD_W-COL_W-IDX_W){1'b0}}, byte_col_next, {IDX_W{1'b0}}});
        job.y     = $signed({base_y_next[ORIGIN_W-1], base_y_next})
                    + $signed({{(COORD_W-DIM_W){1'b0}}, row_next});
        job.value = value_next;
    end

    // Geometry and counter registers advance on each input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_x_reg   <= '0;
            base_y_reg   <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            value_reg    <= '0;
            byte_col_reg <= '0;
            row_reg      <= '0;
        end
        else if (accept)
        begin
            base_x_reg <= base_x_next;
            base_y_reg <= base_y_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            value_reg  <= value_next;
            if (!active)
            begin
                byte_col_reg <= byte_col_next;
                row_reg      <= row_next;
            end
            else if (col_plus >= bytes_per_row)
            begin
                byte_col_reg <= '0;
                row_reg      <= row_next + 8'd1;
            end
            else
            begin
                byte_col_reg <= col_plus[COL_W-1:0];
                row_reg      <= row_next;
            end
        end
    end

    gbe_emitter u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (job),
        .job_valid    (in_valid),
        .job_ready    (in_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .write_value  (write_value),
        .last_of_byte (last_of_byte)
    );

endmodule

@@ rtl/core/gbe_emitter.sv @@
// Pixel emitter: holds one expanded byte, sends its writes one per cycle unless stalled.
// Depends on gbe_pkg for byte_job_t, BIT_MSB and first_pixel().
module gbe_emitter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gbe_pkg::byte_job_t                job,
    input  logic                              job_valid,
    output logic                              job_ready,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [gbe_pkg::COORD_W-1:0] pixel_x,
    output logic signed [gbe_pkg::COORD_W-1:0] pixel_y,
    output logic [gbe_pkg::DIM_W-1:0]          write_value,
    output logic                              last_of_byte
);
    import gbe_pkg::*;

    logic [BYTE_BITS-1:0]      mask_reg;
    logic [BYTE_BITS-1:0]      mask_next;
    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] y_reg;
    logic [DIM_W-1:0]          value_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [COORD_W-1:0] pixel_x_reg;
    logic signed [COORD_W-1:0] pixel_y_reg;
    logic [DIM_W-1:0]          write_value_reg;
    logic                      last_reg;

    logic [IDX_W-1:0]     col;
    logic [BYTE_BITS-1:0] rest_mask;
    logic                 is_last;
    logic                 emit;
    logic                 load;

    // Pick the leftmost pending pixel and see whether it is the final one.
    always_comb
    begin
        col       = first_pixel(mask_reg);
        rest_mask = mask_reg & ~(BIT_MSB >> col);
        is_last   = (rest_mask == '0);
        emit      = (mask_reg != '0) && (!out_valid_reg || out_ready);
        job_ready = (mask_reg == '0) || (emit && is_last);
        load      = job_valid && job_ready;
    end

    // Next pending mask and output valid.
    always_comb
    begin
        if (load)
        begin
            mask_next = job.mask;
        end
        else if (emit)
        begin
            mask_next = rest_mask;
        end
        else
        begin
            mask_next = mask_reg;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Byte payload, captured on each transfer from the input side.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg     <= job.x;
            y_reg     <= job.y;
            value_reg <= job.value;
        end
    end

    // Result register, loaded whenever a pixel write is emitted.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pixel_x_reg     <= x_reg + $signed({{(COORD_W-IDX_W){1'b0}}, col});
            pixel_y_reg     <= y_reg;
            write_value_reg <= value_reg;
            last_reg        <= is_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign write_value  = write_value_reg;
    assign last_of_byte = last_reg;

endmodule

@@ rtl/core/gbe_checker.sv @@
// Port-level checker for the glyph bitmap expander, bound to the top level.
// Depends on gbe_pkg for widths.
module gbe_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [gbe_pkg::COORD_W-1:0] pixel_x,
    input logic signed [gbe_pkg::COORD_W-1:0] pixel_y,
    input logic [gbe_pkg::DIM_W-1:0]          write_value,
    input logic                               last_of_byte
);
    import gbe_pkg::*;

    logic out_xfer;
    assign out_xfer = out_valid && out_ready;

    // A stalled write holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
                                    && $stable(write_value) && $stable(last_of_byte))
        else $error("stalled pixel write changed");

    // Writes of one byte follow each other with no gap.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !last_of_byte |=> out_valid)
        else $error("gap inside the writes of one byte");

    // Writes of one byte share row and value.
    a_same_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !last_of_byte |=> pixel_y == $past(pixel_y)
                                      && write_value == $past(write_value))
        else $error("row or value changed inside one byte");

    // Columns rise within a byte.
    a_col_rise: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !last_of_byte |=> pixel_x > $past(pixel_x))
        else $error("columns not rising inside one byte");

endmodule

bind glyph_bitmap_expander_top gbe_checker u_gbe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .write_value  (write_value),
    .last_of_byte (last_of_byte)
);
